### hdl/quaternion_to_euler_angles_defines.svh
// Assertion macros used by the checker in qte_checker.sv.
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Property checked outside reset.
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  localparam int IN_W   = 34;  // signed CORDIC operand width at the unit boundary
  localparam int VEC_W  = 46;  // internal CORDIC vector width
  localparam int ACC_W  = 26;  // angle accumulator, degrees * 65536
  localparam int ANG_W  = 15;  // signed angle, degrees * 64
  localparam int TAB_LEN = 24;
  localparam int NORM_STAGES = 6;
  localparam int NORM_TOP = 40;
  localparam int ROOT_W = 31;
  localparam int RAD_W  = 61;

  localparam logic signed [ACC_W-1:0] HALF_TURN_FINE = 26'sd11796480;
  localparam logic signed [ACC_W-1:0] ANGLE_LIMIT = 26'sd11520;
  localparam logic signed [15:0] FULL_TURN = 16'sd23040;

  localparam logic [22:0] ATAN_TAB [TAB_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef enum logic [1:0] {
    POLE_NONE  = 2'd0,
    POLE_NORTH = 2'd1,
    POLE_SOUTH = 2'd2
  } pole_t;

  // Operands that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_z;
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] a_h;
    logic signed [IN_W-1:0] b_h;
    logic signed [IN_W-1:0] s;
    pole_t                  pole;
  } side_t;

endpackage

### hdl/qte_sqrt.sv
`timescale 1ns / 1ps
module qte_sqrt import qte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RAD_W-1:0] radicand,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [ROOT_W-1:0] root,
  output side_t            side_out
);

  localparam int REM_W = 35;
  localparam int N_W = 2 * ROOT_W;

  logic [REM_W-1:0]  rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];
  logic [N_W-1:0]    n_q    [ROOT_W+1];
  logic              v_q    [ROOT_W+1];
  side_t             side_q [ROOT_W+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign n_q[0]    = N_W'(radicand);
  assign v_q[0]    = in_valid;
  assign side_q[0] = side_in;

  // One root bit per stage, restoring digit recurrence.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {rem_q[j][REM_W-3:0], n_q[j][N_W-1 -: 2]};
      trial = {(REM_W-2)'(root_q[j]), 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j+1]  <= ge ? cur - trial : cur;
        root_q[j+1] <= {root_q[j][ROOT_W-2:0], ge};
        n_q[j+1]    <= n_q[j] << 2;
        side_q[j+1] <= side_q[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j+1] <= 1'b0;
      end else if (en) begin
        v_q[j+1] <= v_q[j];
      end
    end
  end

  assign out_valid = v_q[ROOT_W];
  assign root      = root_q[ROOT_W];
  assign side_out  = side_q[ROOT_W];

endmodule

### hdl/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
  parameter int STEPS = 16,
  parameter int TAG_W = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [IN_W-1:0]  a_in,
  input  logic signed [IN_W-1:0]  b_in,
  input  logic [TAG_W-1:0]        tag_in,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] angle,
  output logic [TAG_W-1:0]        tag_out
);

  localparam int TOT = 1 + NORM_STAGES + STEPS;

  logic signed [VEC_W-1:0] sa   [TOT];
  logic signed [VEC_W-1:0] sb   [TOT];
  logic signed [ACC_W-1:0] sacc [TOT];
  logic                    skip [TOT];
  logic                    sv   [TOT];
  logic [TAG_W-1:0]        stag [TOT];

  // Fold the left half plane onto the right one, note the base angle.
  always_ff @(posedge clk) begin
    if (en) begin
      skip[0] <= (a_in == '0);
      stag[0] <= tag_in;
      if (b_in < 0) begin
        sa[0]   <= -VEC_W'(a_in);
        sb[0]   <= -VEC_W'(b_in);
        sacc[0] <= (a_in >= 0) ? HALF_TURN_FINE : -HALF_TURN_FINE;
      end else begin
        sa[0]   <= VEC_W'(a_in);
        sb[0]   <= VEC_W'(b_in);
        sacc[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (en) begin
      sv[0] <= in_valid;
    end
  end

  for (genvar k = 1; k < TOT; k++) begin : g_stage
    logic signed [VEC_W-1:0] a_nx;
    logic signed [VEC_W-1:0] b_nx;
    logic signed [ACC_W-1:0] acc_nx;

    if (k <= NORM_STAGES) begin : g_norm
      // Binary search for the scale that lifts the larger magnitude into
      // 2^40 .. 2^41-1.
      localparam int SH = 1 << (NORM_STAGES - k);
      localparam logic signed [VEC_W-1:0] LIM = VEC_W'(64'sd1 <<< (NORM_TOP + 1 - SH));
      logic signed [VEC_W-1:0] ma;
      logic signed [VEC_W-1:0] m;

      always_comb begin
        ma = sa[k-1][VEC_W-1] ? -sa[k-1] : sa[k-1];
        m  = (ma > sb[k-1]) ? ma : sb[k-1];
        if (m < LIM) begin
          a_nx = sa[k-1] <<< SH;
          b_nx = sb[k-1] <<< SH;
        end else begin
          a_nx = sa[k-1];
          b_nx = sb[k-1];
        end
        acc_nx = sacc[k-1];
      end
    end else begin : g_rot
      localparam int I = k - 1 - NORM_STAGES;
      localparam logic signed [ACC_W-1:0] T = ACC_W'(ATAN_TAB[I]);
      logic signed [VEC_W-1:0] da;
      logic signed [VEC_W-1:0] db;

      always_comb begin
        da = sb[k-1] >>> I;
        db = sa[k-1] >>> I;
        if (skip[k-1]) begin
          a_nx   = sa[k-1];
          b_nx   = sb[k-1];
          acc_nx = sacc[k-1];
        end else if (sa[k-1] > 0) begin
          b_nx   = sb[k-1] + db;
          a_nx   = sa[k-1] - da;
          acc_nx = sacc[k-1] + T;
        end else begin
          b_nx   = sb[k-1] - db;
          a_nx   = sa[k-1] + da;
          acc_nx = sacc[k-1] - T;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa[k]   <= a_nx;
        sb[k]   <= b_nx;
        sacc[k] <= acc_nx;
        skip[k] <= skip[k-1];
        stag[k] <= stag[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (en) begin
        sv[k] <= sv[k-1];
      end
    end
  end

  // Round to degrees * 64 and clamp.
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] lim;

  always_comb begin
    rnd = (sacc[TOT-1] + ACC_W'(512)) >>> 10;
    if (rnd > ANGLE_LIMIT) begin
      lim = ANGLE_LIMIT;
    end else if (rnd < -ANGLE_LIMIT) begin
      lim = -ANGLE_LIMIT;
    end else begin
      lim = rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle   <= ANG_W'(lim);
      tag_out <= stag[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sv[TOT-1];
    end
  end

endmodule

### hdl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Quaternion to Euler angles, fully pipelined.
// Input channel s_*: one request per quaternion, components signed Q1.15.
// Output channel m_*: X, Y, Z Euler angles and an absolute heading, all in
// degrees * 64; X and Z wrapped to 0..360 degrees. m_tuser carries the pole
// case of the heading (regular, north pole, south pole).
// Throughput: one request per cycle unless the output stalls. Every stage
// advances together; the pipeline is 4 product/sum stages, a 31-stage square
// root (one root bit per stage, feeding the asin path), 8 + CORDIC_STEPS
// CORDIC stages (fold, six normalize shifts, one micro-rotation per stage,
// round) and one output register.
// The four atan2 units run side by side in the same stages.
// Reset clears every valid bit; payload registers are left as they are.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds,
// s_tready drops and no request is lost or repeated. A bubble in the output
// register lets the pipeline advance even while m_tready is low.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // qw[15:0], qx[31:16], qy[47:32], qz[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // angle_about_x[14:0], angle_about_y[28:15],
                                 // angle_about_z[43:29], heading[59:44], zero pad
  output logic [1:0]  m_tuser    // pole_case[1:0]
);

  typedef struct packed {
    logic signed [31:0] ww, xx, yy, zz, xy, zw, yz, xw, yw, xz;
    logic signed [15:0] x, w;
  } prod_t;

  typedef struct packed {
    logic signed [IN_W-1:0] a_z, b_z, a_x, b_x, s_raw, test, unit;
    logic signed [31:0]     s_sat;
    logic signed [15:0]     x, w;
  } sum_t;

  typedef struct packed {
    logic signed [IN_W-1:0] a_z, b_z, a_x, b_x, s_raw;
    logic signed [31:0]     s_sat;
    logic [RAD_W-1:0]       s_sq;
    logic signed [47:0]     t10k, u4999;
    logic signed [15:0]     x, w;
  } scale_t;

  logic en;
  logic v1, v2, v3, v4;
  prod_t  p1;
  sum_t   p2;
  scale_t p3;
  side_t  p4;
  logic [RAD_W-1:0] rad4;

  // Advance everything whenever the output register is free or being drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [15:0] qw, qx, qy, qz;
  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  // Stage 1: all component products, Q2.30.
  always_ff @(posedge clk) begin
    if (en) begin
      p1.ww <= 32'(qw) * 32'(qw);
      p1.xx <= 32'(qx) * 32'(qx);
      p1.yy <= 32'(qy) * 32'(qy);
      p1.zz <= 32'(qz) * 32'(qz);
      p1.xy <= 32'(qx) * 32'(qy);
      p1.zw <= 32'(qz) * 32'(qw);
      p1.yz <= 32'(qy) * 32'(qz);
      p1.xw <= 32'(qx) * 32'(qw);
      p1.yw <= 32'(qy) * 32'(qw);
      p1.xz <= 32'(qx) * 32'(qz);
      p1.x  <= qx;
      p1.w  <= qw;
    end
  end

  // Stage 2: atan2 operands, asin argument with saturation, pole test terms.
  logic signed [IN_W-1:0] s_raw_c;
  logic signed [31:0]     s_sat_c;

  always_comb begin
    s_raw_c = (IN_W'(p1.yw) - IN_W'(p1.xz)) <<< 1;
    if (s_raw_c > IN_W'(64'sd1 <<< 30)) begin
      s_sat_c = 32'sd1 <<< 30;
    end else if (s_raw_c < -IN_W'(64'sd1 <<< 30)) begin
      s_sat_c = -(32'sd1 <<< 30);
    end else begin
      s_sat_c = 32'(s_raw_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2.a_z   <= (IN_W'(p1.xy) + IN_W'(p1.zw)) <<< 1;
      p2.b_z   <= IN_W'(p1.xx) - IN_W'(p1.yy) - IN_W'(p1.zz) + IN_W'(p1.ww);
      p2.a_x   <= (IN_W'(p1.yz) + IN_W'(p1.xw)) <<< 1;
      p2.b_x   <= IN_W'(p1.zz) + IN_W'(p1.ww) - IN_W'(p1.xx) - IN_W'(p1.yy);
      p2.s_raw <= s_raw_c;
      p2.s_sat <= s_sat_c;
      p2.test  <= IN_W'(p1.xy) + IN_W'(p1.zw);
      p2.unit  <= IN_W'(p1.xx) + IN_W'(p1.yy) + IN_W'(p1.zz) + IN_W'(p1.ww);
      p2.x     <= p1.x;
      p2.w     <= p1.w;
    end
  end

  // Stage 3: square of the asin argument, scaled pole test terms.
  logic signed [63:0] s_sq_c;
  assign s_sq_c = 64'(p2.s_sat) * 64'(p2.s_sat);

  always_ff @(posedge clk) begin
    if (en) begin
      p3.a_z   <= p2.a_z;
      p3.b_z   <= p2.b_z;
      p3.a_x   <= p2.a_x;
      p3.b_x   <= p2.b_x;
      p3.s_raw <= p2.s_raw;
      p3.s_sat <= p2.s_sat;
      p3.s_sq  <= RAD_W'(s_sq_c);
      p3.t10k  <= 48'(p2.test) * 48'sd10000;
      p3.u4999 <= 48'(p2.unit) * 48'sd4999;
      p3.x     <= p2.x;
      p3.w     <= p2.w;
    end
  end

  // Stage 4: square root radicand, pole decision, heading operand select.
  logic  north, south;
  side_t side_c;

  always_comb begin
    north = p3.t10k > p3.u4999;
    south = p3.t10k < -p3.u4999;
    side_c.a_z = p3.a_z;
    side_c.b_z = p3.b_z;
    side_c.a_x = p3.a_x;
    side_c.b_x = p3.b_x;
    side_c.s   = IN_W'(p3.s_sat);
    if (north || south) begin
      side_c.a_h  = IN_W'(p3.x);
      side_c.b_h  = IN_W'(p3.w);
      side_c.pole = north ? POLE_NORTH : POLE_SOUTH;
    end else begin
      side_c.a_h  = p3.s_raw;
      side_c.b_h  = p3.b_z;
      side_c.pole = POLE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4   <= side_c;
      rad4 <= (RAD_W'(1) << 60) - p3.s_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Square root for the asin cosine leg.
  logic              vq;
  logic [ROOT_W-1:0] root_q;
  side_t             sq;

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .radicand  (rad4),
    .side_in   (p4),
    .out_valid (vq),
    .root      (root_q),
    .side_out  (sq)
  );

  // Four atan2 units in lockstep; the heading unit carries the pole case.
  logic signed [ANG_W-1:0] r_x, r_y, r_z, r_h;
  logic                    vc;
  logic [1:0]              pole_c;

  qte_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(2)) u_cordic_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq),
    .a_in(sq.a_x), .b_in(sq.b_x), .tag_in(2'd0),
    .out_valid(), .angle(r_x), .tag_out()
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(2)) u_cordic_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq),
    .a_in(sq.s), .b_in(IN_W'(root_q)), .tag_in(2'd0),
    .out_valid(), .angle(r_y), .tag_out()
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(2)) u_cordic_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq),
    .a_in(sq.a_z), .b_in(sq.b_z), .tag_in(2'd0),
    .out_valid(), .angle(r_z), .tag_out()
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(2)) u_cordic_h (
    .clk(clk), .rst(rst), .en(en), .in_valid(vq),
    .a_in(sq.a_h), .b_in(sq.b_h), .tag_in(sq.pole),
    .out_valid(vc), .angle(r_h), .tag_out(pole_c)
  );

  // Output register: wrap X and Z into 0..360, double the heading at a pole.
  logic signed [15:0] wx, wz, hd;

  always_comb begin
    wx = (r_x < 0) ? 16'(r_x) + FULL_TURN : 16'(r_x);
    wz = (r_z < 0) ? 16'(r_z) + FULL_TURN : 16'(r_z);
    case (pole_t'(pole_c))
      POLE_NORTH: hd = 16'(r_h) <<< 1;
      POLE_SOUTH: hd = -(16'(r_h) <<< 1);
      default:    hd = 16'(r_h);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'b0, hd, 15'(wz), 14'(r_y), 15'(wx)};
      m_tuser <= pole_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vc;
    end
  end

endmodule

### hdl/qte_checker.sv
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_defines.svh"
module qte_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result may follow a reset cycle.
  `QTE_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid, "result valid right after reset")
  // Wrapped angles stay within one turn.
  `QTE_ASSERT(a_wrap,
    m_tvalid |-> (m_tdata[14:0] <= 15'd23040 && m_tdata[43:29] <= 15'd23040),
    "wrapped angle out of range")
  // A pole heading is a doubled angle, hence even.
  `QTE_ASSERT(a_pole_even, (m_tvalid && m_tuser != 2'd0) |-> !m_tdata[44], "odd heading at a pole")
  // A stalled result holds.
  `QTE_ASSERT(a_hold,
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
    "stalled result changed")
  // A waiting request holds.
  `QTE_ASSERT(a_req_hold, (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)),
    "waiting request changed")

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### tb/qte_euler_checker.sv
`timescale 1ns / 1ps
module qte_euler_checker import qte_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [14:0]        ang_x;
    logic signed [13:0] ang_y;
    logic [14:0]        ang_z;
    logic signed [15:0] heading;
    pole_t              pole;
  } euler_t;

  localparam longint ARC_TAB [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  euler_t euler_q[$];

  // Vectoring CORDIC: result in degrees*64, clamped to a half turn.
  function automatic longint arc_tangent(longint a, longint b);
    longint base, acc, r, m, da, db;
    base = 0;
    acc = 0;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      base = (a >= 0) ? 180 * 65536 : -180 * 65536;
      a = -a;
      b = -b;
    end
    if (a != 0) begin
      m = (b > ((a < 0) ? -a : a)) ? b : ((a < 0) ? -a : a);
      for (int k = 0; k < 48 && m < (64'sd1 <<< 40); k++) begin
        a = a * 2;
        b = b * 2;
        m = m * 2;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        da = b >>> i;
        db = a >>> i;
        if (a > 0) begin
          b = b + db;
          a = a - da;
          acc = acc + ARC_TAB[i];
        end else begin
          b = b - db;
          a = a + da;
          acc = acc - ARC_TAB[i];
        end
      end
    end
    r = (base + acc + 512) >>> 10;
    if (r > 11520) r = 11520;
    if (r < -11520) r = -11520;
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n = n - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint wrap_turn(longint v);
    if (v < 0) v = v + 23040;
    if (v > 23040) v = v - 23040;
    return v;
  endfunction

  function automatic euler_t convert_quat(logic [63:0] d);
    longint w, x, y, z, sw, sx, sy, sz, s, c, unit, tst, hd;
    euler_t e;
    w = $signed(d[15:0]);
    x = $signed(d[31:16]);
    y = $signed(d[47:32]);
    z = $signed(d[63:48]);
    sw = w * w; sx = x * x; sy = y * y; sz = z * z;
    e.ang_z = 15'(wrap_turn(arc_tangent(2 * (x * y + z * w), sx - sy - sz + sw)));
    e.ang_x = 15'(wrap_turn(arc_tangent(2 * (y * z + x * w), -sx - sy + sz + sw)));
    // asin argument saturates for unnormalized input
    s = 2 * (y * w - x * z);
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
    c = longint'(root_floor((64'd1 << 60) - longint'(s * s)));
    e.ang_y = 14'(arc_tangent(s, c));
    unit = sx + sy + sz + sw;
    tst = x * y + z * w;
    if (10000 * tst > 4999 * unit) begin
      hd = 2 * arc_tangent(x, w);
      e.pole = POLE_NORTH;
    end else if (10000 * tst < -4999 * unit) begin
      hd = -2 * arc_tangent(x, w);
      e.pole = POLE_SOUTH;
    end else begin
      hd = arc_tangent(2 * (y * w - x * z), sx - sy - sz + sw);
      e.pole = POLE_NONE;
    end
    e.heading = 16'(hd);
    return e;
  endfunction

  assign pending = euler_q.size();

  always @(posedge clk) begin
    euler_t e;
    int nerr;
    nerr = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) euler_q.push_back(convert_quat(s_tdata));
      if (m_tvalid && m_tready) begin
        if (euler_q.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          nerr++;
        end else begin
          e = euler_q.pop_front();
          if (m_tdata[14:0] !== e.ang_x) begin
            $error("angle_about_x exp %0d got %0d", e.ang_x, m_tdata[14:0]);
            nerr++;
          end
          if (m_tdata[28:15] !== e.ang_y) begin
            $error("angle_about_y exp %0d got %0d", e.ang_y, $signed(m_tdata[28:15]));
            nerr++;
          end
          if (m_tdata[43:29] !== e.ang_z) begin
            $error("angle_about_z exp %0d got %0d", e.ang_z, m_tdata[43:29]);
            nerr++;
          end
          if (m_tdata[59:44] !== e.heading) begin
            $error("heading exp %0d got %0d", e.heading, $signed(m_tdata[59:44]));
            nerr++;
          end
          if (m_tuser !== e.pole) begin
            $error("pole_case exp %0d got %0d", e.pole, m_tuser);
            nerr++;
          end
        end
      end
      if (nerr != 0) errors <= errors + nerr;
    end
  end

endmodule

### tb/tb_quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  int          errors, pending;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  quaternion_to_euler_angles dut (.*);

  qte_euler_checker chk (.*);

  // Receiver back-pressure, rate set per phase
  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one request, with random idle cycles first; hold until accepted.
  task automatic send_quat(input int w, x, y, z);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {16'(z), 16'(y), 16'(x), 16'(w)};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  function automatic logic signed [15:0] near(logic signed [15:0] v);
    int t;
    t = int'(v) + $signed($urandom_range(64)) - 32;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return 16'(t);
  endfunction

  task automatic random_quat();
    logic signed [15:0] w, x, y, z;
    w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    case ($urandom_range(4))
      0: ; // full range, often unnormalized
      1: begin
        // halved components, so the norm is at most one
        w = w >>> 1; x = x >>> 1; y = y >>> 1; z = z >>> 1;
      end
      2: begin
        // near north pole: x ~ y, z ~ w
        y = near(x); z = near(w);
      end
      3: begin
        // near south pole: x ~ -y, z ~ -w
        y = near(-x); z = near(-w);
      end
      default: begin
        // tiny w; x, y, z each either zero or left at random
        w = 16'(int'($urandom_range(15)) - 8);
        x = ($urandom_range(1)) ? 16'sd0 : x;
        y = ($urandom_range(1)) ? 16'sd0 : y;
        z = ($urandom_range(1)) ? 16'sd0 : z;
      end
    endcase
    send_quat(int'(w), int'(x), int'(y), int'(z));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, identity, axis extremes, poles, saturated asin
    send_quat(0, 0, 0, 0);
    send_quat(32767, 0, 0, 0);
    send_quat(-32768, 0, 0, 0);
    send_quat(0, 32767, 0, 0);
    send_quat(0, 0, -32768, 0);
    send_quat(0, 0, 0, 32767);
    send_quat(-32768, -32768, -32768, -32768);
    send_quat(32767, 32767, 32767, 32767);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(16384, 16384, -16384, -16384);
    send_quat(-16384, 16384, 16384, -16384);
    send_quat(23170, 0, 23170, 0);
    send_quat(23170, 0, -23170, 0);
    send_quat(32767, 0, 32767, 0);
    send_quat(0, -32768, 32767, 0);
    send_quat(0, 0, 1, 0);
    send_quat(-1, 0, 0, 0);
    send_quat(1, 1, 0, 0);
    send_quat(0, 1, 0, -1);
    send_quat(32767, -32768, 32767, -32768);

    // Random phases: free running, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 61 : (ph == 3) ? 17 : 0;
      recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 17 : 0;
      repeat (163) random_quat();
    end
    s_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
